// ===== src/lers_pkg.sv =====
// Shared types, constants and offset tables for the lane edge row scanner.
package lers_pkg;

  localparam int POS_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_START  = 3'd0,
    REG_RIGHT_START = 3'd1,
    REG_CONTRAST    = 3'd2,
    REG_WHITE_THR   = 3'd3,
    REG_PROBE_GAP   = 3'd4,
    REG_EDGE_RUN    = 3'd5,
    REG_CENTER      = 3'd6
  } cfg_reg_t;

  // start rows at or above this give no reference edge
  localparam logic [5:0] START_ROW_LIMIT = 6'd15;
  localparam int WHITE_TAPS = 10;
  localparam int WHITE_MIN  = 6;
  localparam int HIST_DEPTH = 5;

  localparam logic [5:0] OFFSET_ROM [64] = '{
    6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd40,
    6'd40, 6'd40, 6'd40, 6'd40, 6'd40, 6'd38, 6'd38, 6'd38, 6'd38, 6'd38,
    6'd35, 6'd35, 6'd35, 6'd35, 6'd35, 6'd29, 6'd28, 6'd27, 6'd25, 6'd25,
    6'd24, 6'd24, 6'd24, 6'd24, 6'd23, 6'd23, 6'd23, 6'd23, 6'd22, 6'd22,
    6'd22, 6'd22, 6'd21, 6'd21, 6'd21, 6'd21, 6'd21, 6'd20, 6'd20, 6'd20,
    6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20, 6'd20,
    6'd20, 6'd20, 6'd20, 6'd20
  };

  // each offset divided by three
  localparam logic [5:0] OFFSET_DIV3 [64] = '{
    6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd13,
    6'd13, 6'd13, 6'd13, 6'd13, 6'd13, 6'd12, 6'd12, 6'd12, 6'd12, 6'd12,
    6'd11, 6'd11, 6'd11, 6'd11, 6'd11, 6'd9,  6'd9,  6'd9,  6'd8,  6'd8,
    6'd8,  6'd8,  6'd8,  6'd8,  6'd7,  6'd7,  6'd7,  6'd7,  6'd7,  6'd7,
    6'd7,  6'd7,  6'd7,  6'd7,  6'd7,  6'd7,  6'd7,  6'd6,  6'd6,  6'd6,
    6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,  6'd6,
    6'd6,  6'd6,  6'd6,  6'd6
  };

  function automatic pos_t p8(input logic [7:0] v);
    return pos_t'({3'b000, v});
  endfunction

  function automatic pos_t p6(input logic [5:0] v);
    return pos_t'({5'b00000, v});
  endfunction

endpackage

// ===== src/lers_ram.sv =====
// Generic single-port RAM with registered read.
module lers_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/lane_edge_row_scanner.sv =====
// Lane edge row scanner: frame load, per-row edge search, row results.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  in       | in_valid / in_stall  | pixel, frame_end
//  out      | out_valid / out_stall| row_index, left_edge, right_edge, last_row
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// Load: one pixel per cycle into the frame RAM; in_stall is low while loading.
// Scan: starts after the frame_end beat; INIT_L, INIT_R and INIT_CAP fetch the
// start-row edges, then per row a seed step, two frame RAM reads per probe
// position through its single port, a ten-tap white check per edge run found, plus one result beat.
// Reset: synchronous; edge memory reads as zero until a scan writes it.
// A stalled result holds the scan at the end of the next row.
module lane_edge_row_scanner #(
  parameter int ROWS = 50,
  parameter int COLS = 152
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     pixel,
  input  logic                           frame_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     row_index,
  output logic [7:0]                     left_edge,
  output logic [7:0]                     right_edge,
  output logic                           last_row,
  input  logic                           cfg_we,
  input  logic [lers_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lers_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lers_pkg::*;

  localparam int FRAME = ROWS * COLS;
  localparam int FA_W  = $clog2(FRAME);
  localparam int LA_W  = $clog2(FRAME + 1);
  localparam int SA_W  = FA_W + POS_W;
  localparam int EW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef logic signed [SA_W-1:0] sa_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT_L, ST_INIT_R, ST_INIT_CAP, ST_SEED, ST_POS,
    ST_RD_A, ST_RD_B, ST_EVAL, ST_WHITE, ST_ROW_DONE
  } state_t;

  localparam logic [7:0] COLS8 = 8'(COLS);

  // configuration
  logic [5:0] left_start_row, right_start_row, probe_gap;
  logic [7:0] contrast_delta, white_threshold, center_column;
  logic [4:0] edge_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_start_row  <= '0;
      right_start_row <= '0;
      contrast_delta  <= 8'd20;
      white_threshold <= 8'd128;
      probe_gap       <= 6'd4;
      edge_run        <= 5'd3;
      center_column   <= 8'd76;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEFT_START:  left_start_row  <= cfg_data[5:0];
        REG_RIGHT_START: right_start_row <= cfg_data[5:0];
        REG_CONTRAST:    contrast_delta  <= cfg_data;
        REG_WHITE_THR:   white_threshold <= cfg_data;
        REG_PROBE_GAP:   probe_gap       <= cfg_data[5:0];
        REG_EDGE_RUN:    edge_run        <= cfg_data[4:0];
        REG_CENTER:      center_column   <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t           state;
  logic [LA_W-1:0]  load_address;
  logic [5:0]       cur;
  logic [FA_W-1:0]  row_base;
  pos_t             lp1, lp3;
  logic             side_left, in_run, lfound, rfound;
  logic [5:0]       cnt;
  logic [3:0]       wk, xx;
  logic [7:0]       pa, ledge, redge, l0_q, r0_q;
  logic             oob_q, ev_q;
  logic [7:0]       hl [HIST_DEPTH];
  logic [7:0]       hr [HIST_DEPTH];
  logic [ROWS-1:0]  evalid;

  logic             in_accept, slot_free, fire_row;
  logic             fr_we, e_we;
  logic [FA_W-1:0]  fr_addr;
  logic [7:0]       fr_rdata, pix;
  logic [EW-1:0]    e_addr;
  logic [15:0]      e_rdata;
  logic [7:0]       lres, rres;

  pos_t g, run, cols_p, lp2, lp4, rd_col;
  sa_t  rd_sa;
  logic rd_oob;

  assign g      = p6(probe_gap);
  assign run    = pos_t'({6'b0, edge_run});
  assign cols_p = pos_t'(COLS);
  assign lp2    = lp1 + g;
  assign lp4    = lp3 + g;

  assign in_stall  = (state != ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign fire_row  = (state == ST_ROW_DONE) && slot_free;

  // pixel read column
  always_comb begin
    unique case (state)
      ST_RD_A:  rd_col = side_left ? lp1 : lp4;
      ST_RD_B:  rd_col = side_left ? lp2 : lp3;
      ST_WHITE: rd_col = side_left ? (lp2 - run - pos_t'({7'b0, wk}))
                                   : (lp3 + run + pos_t'({7'b0, wk}));
      default:  rd_col = lp3;
    endcase
  end

  assign rd_sa  = sa_t'({1'b0, row_base}) + sa_t'(rd_col);
  assign rd_oob = (rd_sa < 0) || (rd_sa >= sa_t'(FRAME));

  assign fr_we   = in_accept && (load_address < LA_W'(FRAME));
  assign fr_addr = (state == ST_LOAD) ? load_address[FA_W-1:0] : rd_sa[FA_W-1:0];
  assign pix     = oob_q ? 8'd0 : fr_rdata;

  lers_ram #(.WIDTH(8), .DEPTH(FRAME)) u_frame (
    .clk   (clk),
    .we    (fr_we),
    .addr  (fr_addr),
    .wdata (pixel),
    .rdata (fr_rdata)
  );

  assign lres = lfound ? ledge : COLS8;
  assign rres = rfound ? redge : 8'd0;
  assign e_we = fire_row;

  always_comb begin
    unique case (state)
      ST_INIT_L: e_addr = left_start_row[EW-1:0];
      ST_INIT_R: e_addr = right_start_row[EW-1:0];
      default:   e_addr = cur[EW-1:0];
    endcase
  end

  lers_ram #(.WIDTH(16), .DEPTH(ROWS)) u_edges (
    .clk   (clk),
    .we    (e_we),
    .addr  (e_addr),
    .wdata ({lres, rres}),
    .rdata (e_rdata)
  );

  // ---------------- window seeding ----------------
  logic       lok, rok, lgot, rgot;
  logic [7:0] l0, r0, le_sel, re_sel, pl8, pr8;
  logic [5:0] lrow, rrow;
  pos_t       oL, oR, pl, pr, e_l, o_l, od3_l, e_r, o_r;
  pos_t       seed_lp1, seed_lp3;

  assign lok = (left_start_row < START_ROW_LIMIT) && (int'(left_start_row) < ROWS);
  assign rok = (right_start_row < START_ROW_LIMIT) && (int'(right_start_row) < ROWS);
  assign l0  = lok ? l0_q : COLS8;
  assign r0  = rok ? r0_q : 8'd0;
  assign oL  = p6(OFFSET_ROM[left_start_row]);
  assign oR  = p6(OFFSET_ROM[right_start_row]);
  assign pl8 = hl[0];
  assign pr8 = hr[0];
  assign pl  = p8(pl8);
  assign pr  = p8(pr8);

  // nearest row above (down to five back, not below row 0) with an edge
  always_comb begin
    lgot   = 1'b0;
    rgot   = 1'b0;
    le_sel = '0;
    re_sel = '0;
    lrow   = '0;
    rrow   = '0;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      if (!lgot && (k < int'(cur)) && (hl[k] != COLS8)) begin
        lgot   = 1'b1;
        le_sel = hl[k];
        lrow   = cur - 6'(k + 1);
      end
      if (!rgot && (k < int'(cur)) && (hr[k] != 8'd0)) begin
        rgot   = 1'b1;
        re_sel = hr[k];
        rrow   = cur - 6'(k + 1);
      end
    end
  end

  assign e_l   = p8(le_sel);
  assign o_l   = p6(OFFSET_ROM[lrow]);
  assign od3_l = p6(OFFSET_DIV3[lrow]);
  assign e_r   = p8(re_sel);
  assign o_r   = p6(OFFSET_ROM[rrow]);

  always_comb begin
    if (cur == 6'd0) begin
      if (lok && (l0 != COLS8) && (l0 != 8'd0)) begin
        seed_lp1 = (p8(l0) > oL + pos_t'(1)) ? p8(l0) - oL : pos_t'(1);
      end else if (rok && (r0 != 8'd0)) begin
        seed_lp1 = (p8(r0) + oR > cols_p - g - pos_t'(10)) ? cols_p - g - pos_t'(10)
                                                          : p8(r0) + oR;
      end else begin
        seed_lp1 = p8(center_column);
      end
      if (rok && (r0 != 8'd0)) begin
        seed_lp3 = (p8(r0) + oR < cols_p - g - pos_t'(5)) ? p8(r0) + oR
                                                         : cols_p - g - pos_t'(5);
      end else if (lok && (l0 != COLS8)) begin
        seed_lp3 = (p8(l0) > oL + pos_t'(5)) ? p8(l0) - oL : pos_t'(5);
      end else begin
        seed_lp3 = p8(center_column);
      end
    end else begin
      if (lgot) begin
        if (e_l > o_l) begin
          if ((pr8 != 8'd0) && (e_l - o_l < pr + pos_t'(5))) seed_lp1 = pr + pos_t'(5);
          else seed_lp1 = e_l - od3_l;
        end else begin
          if ((pr8 != 8'd0) && (pr + pos_t'(5) < cols_p - g)) seed_lp1 = pr + pos_t'(5);
          else seed_lp1 = pos_t'(1);
        end
      end else if (pr8 != 8'd0) begin
        seed_lp1 = (pr + pos_t'(5) > cols_p - g - pos_t'(10)) ? cols_p - g - pos_t'(10)
                                                             : pr + pos_t'(5);
      end else begin
        seed_lp1 = p8(center_column);
      end
      if (rgot) begin
        if (e_r + o_r < cols_p - g - pos_t'(5)) begin
          if ((pl8 != COLS8) && (e_r + o_r > pl - g - pos_t'(5))) seed_lp3 = pl - g - pos_t'(5);
          else seed_lp3 = e_r;
        end else if (pl8 == COLS8) begin
          seed_lp3 = cols_p - g - pos_t'(5);
        end else if (pl > g + pos_t'(5)) begin
          seed_lp3 = pl - g - pos_t'(5);
        end else begin
          seed_lp3 = p8(center_column);
        end
      end else if (pl8 != COLS8) begin
        seed_lp3 = (pl > g + pos_t'(10)) ? pl - g - pos_t'(5) : pos_t'(5);
      end else begin
        seed_lp3 = p8(center_column);
      end
    end
  end

  // ---------------- probe evaluation ----------------
  logic       contrast, white_hit;
  logic [5:0] cnt_n;
  logic [3:0] xx_total;

  assign contrast  = {1'b0, pa} > ({1'b0, contrast_delta} + {1'b0, pix});
  assign cnt_n     = (in_run ? cnt : 6'd0) + {5'b0, (pa != 8'hFF)};
  assign white_hit = pix > white_threshold;
  assign xx_total  = xx + {3'b0, white_hit};

  always_ff @(posedge clk) begin
    oob_q <= rd_oob;
    ev_q  <= evalid[e_addr];
    if (rst) begin
      state        <= ST_LOAD;
      load_address <= '0;
      out_valid    <= 1'b0;
      evalid       <= '0;
      cur          <= '0;
      row_base     <= '0;
    end else begin
      if (out_valid && !out_stall && !fire_row) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (frame_end) begin
              load_address <= '0;
              cur          <= '0;
              row_base     <= '0;
              state        <= ST_INIT_L;
            end else if (fr_we) begin
              load_address <= load_address + LA_W'(1);
            end
          end
        end
        ST_INIT_L: state <= ST_INIT_R;
        ST_INIT_R: begin
          l0_q  <= ev_q ? e_rdata[15:8] : 8'd0;
          state <= ST_INIT_CAP;
        end
        ST_INIT_CAP: begin
          r0_q  <= ev_q ? e_rdata[7:0] : 8'd0;
          state <= ST_SEED;
        end
        ST_SEED: begin
          lp1       <= seed_lp1;
          lp3       <= seed_lp3;
          side_left <= 1'b0;
          in_run    <= 1'b0;
          lfound    <= 1'b0;
          rfound    <= 1'b0;
          state     <= ST_POS;
        end
        ST_POS: begin
          if (!side_left) begin
            if (lp3 <= 0) begin
              side_left <= 1'b1;
              in_run    <= 1'b0;
            end else begin
              state <= ST_RD_A;
            end
          end else if (lp2 >= cols_p) begin
            state <= ST_ROW_DONE;
          end else begin
            state <= ST_RD_A;
          end
        end
        ST_RD_A: state <= ST_RD_B;
        ST_RD_B: begin
          pa    <= pix;
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (side_left) lp1 <= lp1 + pos_t'(1);
          else           lp3 <= lp3 - pos_t'(1);
          if (contrast) begin
            in_run <= 1'b1;
            cnt    <= cnt_n;
            if (cnt_n >= {1'b0, edge_run}) begin
              wk    <= '0;
              xx    <= '0;
              state <= ST_WHITE;
            end else begin
              state <= ST_POS;
            end
          end else begin
            in_run <= 1'b0;
            state  <= ST_POS;
          end
        end
        ST_WHITE: begin
          // read for tap wk goes out now, data of tap wk-1 comes back
          if (wk != 4'd0) begin
            xx <= xx_total;
          end
          if (wk == 4'(WHITE_TAPS)) begin
            in_run <= 1'b0;
            if (int'(xx_total) > WHITE_MIN) begin
              if (side_left) begin
                lfound <= 1'b1;
                ledge  <= 8'(lp2 - run);
                state  <= ST_ROW_DONE;
              end else begin
                rfound    <= 1'b1;
                redge     <= 8'(lp3 + run);
                side_left <= 1'b1;
                state     <= ST_POS;
              end
            end else begin
              state <= ST_POS;
            end
          end else begin
            wk <= wk + 4'd1;
          end
        end
        ST_ROW_DONE: begin
          if (slot_free) begin
            out_valid   <= 1'b1;
            row_index   <= cur;
            left_edge   <= lres;
            right_edge  <= rres;
            last_row    <= (int'(cur) == ROWS - 1);
            evalid[cur[EW-1:0]] <= 1'b1;
            hl[0] <= lres;
            hr[0] <= rres;
            for (int k = 1; k < HIST_DEPTH; k++) begin
              hl[k] <= hl[k-1];
              hr[k] <= hr[k-1];
            end
            if (int'(cur) == ROWS - 1) begin
              state <= ST_LOAD;
            end else begin
              cur      <= cur + 6'd1;
              row_base <= row_base + FA_W'(COLS);
              state    <= ST_SEED;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

// ===== src/lers_checker.sv =====
// Port-level checks for the lane edge row scanner, bound to the top level.
module lers_checker #(
  parameter int ROWS = 50
) (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       frame_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] row_index,
  input logic [7:0] left_edge,
  input logic [7:0] right_edge,
  input logic       last_row
);

  // a frame_end beat starts the scan, which holds off input
  a_scan_stalls_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && frame_end |=> in_stall)
    else $error("input taken right after frame_end");

  // every row but the last is reported while the scan still runs
  a_rows_during_scan: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> in_stall)
    else $error("non-final row shown outside a scan");

  a_last_row_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_row |-> row_index == 6'(ROWS - 1))
    else $error("last_row on wrong row");

  a_no_result_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_row |=> !out_valid)
    else $error("result beat right after the final row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(left_edge)
      && $stable(right_edge) && $stable(last_row))
    else $error("stalled result changed");

endmodule

bind lane_edge_row_scanner lers_checker #(.ROWS(ROWS)) u_lers_checker (.*);
